// File: rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg: shared constants and helpers for the quaternion to Euler block
// Widths, the arctangent table and the angle rounding used by all stages.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AtanTableLen    = 24;
  // CORDIC datapath: operands are Q.28 and grow by at most ~2 bits.
  localparam int unsigned CW = 36;
  // Angle accumulator, Q.30.
  localparam int unsigned ZW = 33;
  // Square root operand 2^56 - s^2 fits in 57 bits, root in 29.
  localparam int unsigned RadW  = 58;
  localparam int unsigned RootW = 29;

  localparam logic signed [ZW-1:0] HalfPiQ30 = 33'sd1686629713;
  localparam logic signed [CW-1:0] OneQ28    = 36'sd268435456;
  localparam logic signed [15:0]   PiQ13     = 16'sd25736;
  localparam logic signed [15:0]   HalfPiQ13 = 16'sd12868;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      5'd0:  r = 33'sd843314856;
      5'd1:  r = 33'sd497837829;
      5'd2:  r = 33'sd263043836;
      5'd3:  r = 33'sd133525158;
      5'd4:  r = 33'sd67021686;
      5'd5:  r = 33'sd33543515;
      5'd6:  r = 33'sd16775850;
      5'd7:  r = 33'sd8388437;
      5'd8:  r = 33'sd4194282;
      5'd9:  r = 33'sd2097149;
      5'd10: r = 33'sd1048575;
      5'd11: r = 33'sd524287;
      5'd12: r = 33'sd262143;
      5'd13: r = 33'sd131071;
      5'd14: r = 33'sd65535;
      5'd15: r = 33'sd32767;
      5'd16: r = 33'sd16383;
      5'd17: r = 33'sd8191;
      5'd18: r = 33'sd4095;
      5'd19: r = 33'sd2047;
      5'd20: r = 33'sd1023;
      5'd21: r = 33'sd511;
      5'd22: r = 33'sd255;
      5'd23: r = 33'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round Q.30 to Q3.13 with floor after adding half, then saturate to +-lim.
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] a,
                                                input logic signed [15:0] lim);
    logic signed [ZW:0] s;
    logic signed [ZW:0] r;
    s = {a[ZW-1], a} + (ZW+1)'(65536);
    r = s >>> 17;
    if (r > (ZW+1)'(lim)) return lim;
    if (r < -((ZW+1)'(lim))) return -lim;
    return r[15:0];
  endfunction

endpackage

// File: rtl/q2e_sqrt_stage.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_stage: one registered step of a restoring integer square root
// Settles two bits of remainder and one root bit per stage.
// ----------------------------------------------------------------------------
module q2e_sqrt_stage #(
  parameter int unsigned Step = 0
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [q2e_pkg::RadW-1:0]        rem_i,
  input  logic [q2e_pkg::RootW-1:0]       root_i,
  output logic [q2e_pkg::RadW-1:0]        rem_o,
  output logic [q2e_pkg::RootW-1:0]       root_o
);
  localparam int unsigned Sh = 2 * (q2e_pkg::RootW - 1 - Step);

  logic [q2e_pkg::RadW-1:0]  trial;
  logic [q2e_pkg::RadW-1:0]  rem_d, rem_q;
  logic [q2e_pkg::RootW-1:0] root_d, root_q;

  always_comb begin
    // trial = (4*root + 1) << Sh, root holds the bits settled so far
    trial = ({{(q2e_pkg::RadW-q2e_pkg::RootW-2){1'b0}}, root_i, 2'b01}) << Sh;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = {root_i[q2e_pkg::RootW-2:0], 1'b1};
    end else begin
      rem_d  = rem_i;
      root_d = {root_i[q2e_pkg::RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule

// File: rtl/q2e_cordic_stage.sv
// ----------------------------------------------------------------------------
// q2e_cordic_stage: one registered vectoring rotation of the CORDIC
// Drives y toward zero and accumulates the turned angle.
// ----------------------------------------------------------------------------
module q2e_cordic_stage #(
  parameter int unsigned Step = 0
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [q2e_pkg::CW-1:0]     x_i,
  input  logic signed [q2e_pkg::CW-1:0]     y_i,
  input  logic signed [q2e_pkg::ZW-1:0]     z_i,
  output logic signed [q2e_pkg::CW-1:0]     x_o,
  output logic signed [q2e_pkg::CW-1:0]     y_o,
  output logic signed [q2e_pkg::ZW-1:0]     z_o
);
  logic signed [q2e_pkg::CW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [q2e_pkg::ZW-1:0] z_d, z_q, ang;

  always_comb begin
    dx  = y_i >>> Step;
    dy  = x_i >>> Step;
    ang = q2e_pkg::atan_q30(5'(Step));
    if (!y_i[q2e_pkg::CW-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ang;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

// File: rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: Z-Y-X Euler angles from a Q2.14 quaternion
// Products, a pipelined square root and three pipelined CORDIC vectoring
// units produce roll, pitch and yaw in Q3.13 radians.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                     | tuser
//  s_axis  | in  | quat_w, quat_x, quat_y, quat_z (4 x 16)   | -
//  m_axis  | out | roll 16, pitch 15, yaw 16, pad 1 (48 bits) | pitch_clamped
//
//  One quaternion enters each cycle while the output is not stalled; a result
//  leaves through the product, operand, square root, pre-rotation, CORDIC
//  and output registers. Latency is set by the square root (one root bit per
//  stage) followed by the CORDIC units; the roll and yaw operands ride along
//  in delay registers beside the root. The whole pipe advances together;
//  m_axis_tready low with a beat in the last stage holds every stage, and
//  s_axis_tready is low only in that case. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STAGES = q2e_pkg::CordicStagesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, 0
  output logic        m_axis_tuser    // pitch_clamped
);
  localparam int unsigned CW    = q2e_pkg::CW;
  localparam int unsigned ZW    = q2e_pkg::ZW;
  localparam int unsigned RadW  = q2e_pkg::RadW;
  localparam int unsigned RootW = q2e_pkg::RootW;
  localparam int unsigned Stg   = (CORDIC_STAGES < q2e_pkg::AtanTableLen) ?
                                  CORDIC_STAGES : q2e_pkg::AtanTableLen;
  // valid pipeline: products, operands, sqrt stages, pre-rotate, cordic, out
  localparam int unsigned Depth = 2 + RootW + 1 + Stg + 1;

  logic             en;
  logic [Depth-1:0] vld_q;

  // The pipe moves as one; it holds only when the output beat is unclaimed.
  assign en            = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  // ---- stage 1: products ---------------------------------------------------
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= qw * qx; yz_q <= qy * qz; xx_q <= qx * qx;
      yy_q <= qy * qy; wz_q <= qw * qz; xy_q <= qx * qy;
      zz_q <= qz * qz; wy_q <= qw * qy; zx_q <= qz * qx;
    end
  end

  // ---- stage 2: atan2 operands, clamp test, sqrt radicand -------------------
  logic signed [CW-1:0] sr_d, cr_d, sy_d, cy_d, sp_d;
  logic signed [CW-1:0] sr_q, cr_q, sy_q, cy_q, sp_q;
  logic [RadW-1:0]      rad_d, rad_q;
  logic                 clp_d, clp_q;
  logic signed [28:0]   sp_n;
  logic signed [RadW-1:0] sp2;

  always_comb begin
    sr_d = (CW'(wx_q) + CW'(yz_q)) <<< 1;
    cr_d = q2e_pkg::OneQ28 - ((CW'(xx_q) + CW'(yy_q)) <<< 1);
    sy_d = (CW'(wz_q) + CW'(xy_q)) <<< 1;
    cy_d = q2e_pkg::OneQ28 - ((CW'(yy_q) + CW'(zz_q)) <<< 1);
    sp_d = (CW'(wy_q) - CW'(zx_q)) <<< 1;
    clp_d = (sp_d >= q2e_pkg::OneQ28) || (sp_d <= -q2e_pkg::OneQ28);
    // |sp| < 2^28 when not clamped, so 29 bits hold it; 29x29-bit square
    sp_n = sp_d[28:0];
    sp2  = sp_n * sp_n;
    rad_d = clp_d ? '0 : (RadW'(1) << 56) - RadW'(sp2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q <= sr_d; cr_q <= cr_d; sy_q <= sy_d; cy_q <= cy_d; sp_q <= sp_d;
      rad_q <= rad_d; clp_q <= clp_d;
    end
  end

  // ---- square root pipeline; side operands delayed alongside -------------
  logic [RadW-1:0]  rem_w  [RootW+1];
  logic [RootW-1:0] root_w [RootW+1];
  logic signed [CW-1:0] dsr_q [RootW+1];
  logic signed [CW-1:0] dcr_q [RootW+1];
  logic signed [CW-1:0] dsy_q [RootW+1];
  logic signed [CW-1:0] dcy_q [RootW+1];
  logic signed [CW-1:0] dsp_q [RootW+1];
  logic                 dcl_q [RootW+1];

  assign rem_w[0]  = rad_q;
  assign root_w[0] = '0;
  assign dsr_q[0] = sr_q; assign dcr_q[0] = cr_q; assign dsy_q[0] = sy_q;
  assign dcy_q[0] = cy_q; assign dsp_q[0] = sp_q; assign dcl_q[0] = clp_q;

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    q2e_sqrt_stage #(.Step(g)) u_sqrt (
      .clk_i (clk_i), .en_i(en),
      .rem_i (rem_w[g]), .root_i(root_w[g]),
      .rem_o (rem_w[g+1]), .root_o(root_w[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        dsr_q[g+1] <= dsr_q[g]; dcr_q[g+1] <= dcr_q[g]; dsy_q[g+1] <= dsy_q[g];
        dcy_q[g+1] <= dcy_q[g]; dsp_q[g+1] <= dsp_q[g]; dcl_q[g+1] <= dcl_q[g];
      end
    end
  end

  // ---- pre-rotation into the right half plane ------------------------------
  logic signed [CW-1:0] px_d [3], py_d [3], px_q [3], py_q [3];
  logic signed [ZW-1:0] pz_d [3], pz_q [3];
  logic                 zero_d [3], zero_q [3];
  logic signed [CW-1:0] ay [3], ax [3];
  logic                 pcl_q;

  assign ay[0] = dsr_q[RootW]; assign ax[0] = dcr_q[RootW];
  assign ay[1] = dsp_q[RootW]; assign ax[1] = CW'({1'b0, root_w[RootW]});
  assign ay[2] = dsy_q[RootW]; assign ax[2] = dcy_q[RootW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      zero_d[k] = (ax[k] == '0) && (ay[k] == '0);
      if (ax[k][CW-1]) begin
        if (!ay[k][CW-1]) begin
          px_d[k] = ay[k]; py_d[k] = -ax[k]; pz_d[k] = q2e_pkg::HalfPiQ30;
        end else begin
          px_d[k] = -ay[k]; py_d[k] = ax[k]; pz_d[k] = -q2e_pkg::HalfPiQ30;
        end
      end else begin
        px_d[k] = ax[k]; py_d[k] = ay[k]; pz_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= px_d; py_q <= py_d; pz_q <= pz_d; zero_q <= zero_d;
      pcl_q <= dcl_q[RootW];
    end
  end

  // ---- three CORDIC pipelines ------------------------------------------------
  logic signed [CW-1:0] cx [3][Stg+1];
  logic signed [CW-1:0] cy [3][Stg+1];
  logic signed [ZW-1:0] cz [3][Stg+1];
  logic                 czero_q [Stg+1][3];
  logic                 ccl_q [Stg+1];

  assign czero_q[0] = zero_q;
  assign ccl_q[0]   = pcl_q;

  for (genvar u = 0; u < 3; u++) begin : g_unit
    assign cx[u][0] = px_q[u];
    assign cy[u][0] = py_q[u];
    assign cz[u][0] = pz_q[u];
    for (genvar s = 0; s < Stg; s++) begin : g_stage
      q2e_cordic_stage #(.Step(s)) u_stage (
        .clk_i(clk_i), .en_i(en),
        .x_i(cx[u][s]), .y_i(cy[u][s]), .z_i(cz[u][s]),
        .x_o(cx[u][s+1]), .y_o(cy[u][s+1]), .z_o(cz[u][s+1])
      );
    end
  end

  for (genvar s = 0; s < Stg; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        czero_q[s+1] <= czero_q[s];
        ccl_q[s+1]   <= ccl_q[s];
      end
    end
  end

  // ---- output rounding and register ------------------------------------------
  logic signed [15:0] roll_d, pitch_d, yaw_d;
  logic [47:0]        tdata_q;
  logic               tuser_q;

  always_comb begin
    roll_d = czero_q[Stg][0] ? '0 : q2e_pkg::to_q13(cz[0][Stg], q2e_pkg::PiQ13);
    yaw_d  = czero_q[Stg][2] ? '0 : q2e_pkg::to_q13(cz[2][Stg], q2e_pkg::PiQ13);
    if (ccl_q[Stg]) begin
      // clamp sign comes from the sine and travels in csg_q; here use sign of y
      pitch_d = cy[1][0][CW-1] ? -q2e_pkg::HalfPiQ13 : q2e_pkg::HalfPiQ13;
    end else begin
      pitch_d = czero_q[Stg][1] ? '0 :
                q2e_pkg::to_q13(cz[1][Stg], q2e_pkg::HalfPiQ13);
    end
  end

  // clamp sign must travel with the beat
  logic csg_q [Stg+1];
  assign csg_q[0] = py_q[1][CW-1] ^ px_q[1][CW-1];
  for (genvar s = 0; s < Stg; s++) begin : g_sgn
    always_ff @(posedge clk_i) begin
      if (en) csg_q[s+1] <= csg_q[s];
    end
  end

  logic signed [15:0] pitch_f;
  always_comb begin
    pitch_f = pitch_d;
    if (ccl_q[Stg]) pitch_f = csg_q[Stg] ? -q2e_pkg::HalfPiQ13 : q2e_pkg::HalfPiQ13;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {1'b0, yaw_d, pitch_f[14:0], roll_d};
      tuser_q <= ccl_q[Stg];
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;
endmodule

// File: rtl/q2e_checker.sv
// ----------------------------------------------------------------------------
// q2e_port_props: port-level checks for the quaternion to Euler block
// Watches the stream handshakes and result ranges.
// ----------------------------------------------------------------------------
module q2e_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  // output beat holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");

  // input side opens whenever the output is taken
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with output free");

  // a clamped pitch is exactly plus or minus half pi
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[30:16] == 15'sd12868) || (m_axis_tdata[30:16] == -15'sd12868))
    else $error("clamped pitch not at half pi");

  // padding bit stays clear
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[47])
    else $error("pad bit set");
endmodule

bind quaternion_to_euler_angles q2e_port_props u_q2e_port_props (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// File: tb/q2e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_checker: angle predictor and result checker for quaternion_to_euler_angles
// Watches both stream channels, computes the expected roll, pitch and yaw for
// each accepted quaternion and compares every output beat with the oldest one.
// ----------------------------------------------------------------------------
module q2e_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, 0
  input  logic        m_axis_tuser,   // pitch_clamped
  output int          errors_o,
  output int          pending_o
);

  localparam int      Stages   = q2e_pkg::CordicStagesDef;
  localparam longint  OneQ28   = 64'sd268435456;
  localparam longint  HalfPi30 = 64'sd1686629713;
  localparam longint  Pi13     = 25736;
  localparam longint  HalfPi13 = 12868;

  localparam longint ArcTab [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  typedef struct packed {
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] yaw;
    logic        clamped;
  } angles_t;

  angles_t angles_q[$];

  assign pending_o = angles_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC, result in Q.30 radians.
  function automatic longint vector_angle(longint yv, longint xv);
    longint z = 0;
    longint t, dx, dy;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t; z = HalfPi30;
      end else begin
        t = xv; xv = -yv; yv = t; z = -HalfPi30;
      end
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; z += ArcTab[i];
      end else begin
        xv -= dx; yv += dy; z -= ArcTab[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = (a + 65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_from_quat(logic [63:0] q);
    angles_t e;
    longint w, x, y, z, sr, cr, sy, cy, sp, c, p;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    sr = 2 * (w * x + y * z);
    cr = OneQ28 - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = OneQ28 - 2 * (y * y + z * z);
    sp = 2 * (w * y - z * x);
    e.roll    = 16'(round_q13(vector_angle(sr, cr), Pi13));
    e.yaw     = 16'(round_q13(vector_angle(sy, cy), Pi13));
    e.clamped = 1'b0;
    if (sp >= OneQ28) begin
      p = HalfPi13; e.clamped = 1'b1;
    end else if (sp <= -OneQ28) begin
      p = -HalfPi13; e.clamped = 1'b1;
    end else begin
      c = longint'(int_sqrt((64'd1 << 56) - longint'(sp * sp)));
      p = round_q13(vector_angle(sp, c), HalfPi13);
    end
    e.pitch = 15'(p);
    return e;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) angles_q.push_back(euler_from_quat(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (angles_q.size() == 0) begin
          report("unexpected beat", 1, 0);
        end else begin
          want = angles_q.pop_front();
          if (m_axis_tdata[15:0] !== want.roll)
            report("roll", $signed(m_axis_tdata[15:0]), $signed(want.roll));
          if (m_axis_tdata[30:16] !== want.pitch)
            report("pitch", $signed(m_axis_tdata[30:16]), $signed(want.pitch));
          if (m_axis_tdata[46:31] !== want.yaw)
            report("yaw", $signed(m_axis_tdata[46:31]), $signed(want.yaw));
          if (m_axis_tdata[47] !== 1'b0) report("pad bit", m_axis_tdata[47], 0);
          if (m_axis_tuser !== want.clamped) report("clamp", m_axis_tuser, want.clamped);
        end
      end
    end
  end

endmodule

// File: tb/quaternion_to_euler_angles_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb: stimulus and verdict for the Euler converter
// Sends directed and random quaternions with random gaps and output stalls;
// the checker predicts each angle set and counts mismatches.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;

  localparam int RandomBeats = 630;
  localparam int IdleLimit   = 5000;   // well above a long stall plus latency
  localparam int DrainCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;      // quat_w, quat_x, quat_y, quat_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;           // roll_angle, pitch_angle, yaw_angle, 0
  logic        m_axis_tuser;           // pitch_clamped

  int errors;
  int pending;
  int idle_cycles = 0;
  bit hold_rx = 1'b0;                  // ask the receiver for one long hold-off
  bit no_gaps = 1'b0;                  // sender burst mode

  always #5 clk_i = ~clk_i;

  quaternion_to_euler_angles dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  q2e_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o (errors), .pending_o (pending)
  );

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Send one quaternion; tready is stable from the falling edge to the next rise.
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    bit rdy;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x, w};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rand_component();
    if ($urandom_range(0, 9) < 3) return 16'($urandom());
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // Receiver: random stalls, stall-free stretches, and one long hold-off.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_rx = 1'b0;
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] cw;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, zero vector, operand extremes, gimbal lock both ways,
    // negative cosine operand with both sine signs, out-of-range inputs.
    send_quat(16'sd16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_quat(16'sd16384, 0, 16'sd16384, 0);
    send_quat(16'sd16384, 0, -16'sd16384, 0);
    send_quat(16'sd11585, 0, 16'sd11585, 0);
    send_quat(16'sd11585, 0, -16'sd11585, 0);
    send_quat(16'sd11586, 0, 16'sd11586, 0);
    send_quat(0, 16'sd16384, 0, 0);
    send_quat(-16'sd16384, 16'sd16384, 0, 0);
    send_quat(16'sd16384, 16'sd16384, 0, 0);
    send_quat(0, 0, 0, 16'sd16384);
    send_quat(-16'sd16384, 0, 0, 16'sd16384);
    send_quat(0, 0, 16'sd16384, 0);
    send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_quat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_quat(0, 16'sd11585, 0, 16'sd11585);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);

    // Pause until the pipe has drained.
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);

    // Fill the pipe against a long receiver hold-off.
    hold_rx = 1'b1;
    no_gaps = 1'b1;
    repeat (80) send_quat(rand_component(), rand_component(), rand_component(),
                          rand_component());

    for (int i = 0; i < RandomBeats - 80; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // Near gimbal lock.
        cw = 16'($urandom_range(11560, 11610));
        send_quat(cw, 16'($urandom_range(0, 40) - 20),
                  $urandom_range(0, 1) ? cw : -cw, 16'($urandom_range(0, 40) - 20));
      end else begin
        send_quat(rand_component(), rand_component(), rand_component(),
                  rand_component());
      end
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
